// File: rtl/event_pattern_histogram_core_macros.svh
// Assertion macros shared by the histogram core RTL.
`ifndef EVENT_PATTERN_HISTOGRAM_CORE_MACROS_SVH
`define EVENT_PATTERN_HISTOGRAM_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EPHC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define EPHC_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define EPHC_ASSERT(label, clk, rst, prop, msg)
`define EPHC_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/ephc_pkg.sv
// Types and constants of the event pattern histogram core.
package ephc_pkg;

  localparam int EVENT_W     = 32;
  localparam int INDEX_W     = 16;
  localparam int COUNT_W     = 32;
  localparam int ADDR_MAX_W  = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

endpackage

// File: rtl/ephc_ifs.sv
// Handshake interfaces for the input items and the result items.
interface ephc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ephc_pkg::EVENT_W-1:0] event_word;
  logic [ephc_pkg::INDEX_W-1:0] bin_index;

  modport source (output valid, kind, event_word, bin_index, input ready);
  modport sink (input valid, kind, event_word, bin_index, output ready);
endinterface

interface ephc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ephc_pkg::COUNT_W-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink (input valid, bin_count, output ready);
endinterface

// File: rtl/ephc_front.sv
// Front end: accepts items, classifies them and queues work for the back end.
`include "event_pattern_histogram_core_macros.svh"

module ephc_front #(
  parameter int CHANNELS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  ephc_in_if.sink                item,
  input  logic                   clearing,
  input  logic                   pop,
  output ephc_pkg::queue_head_t  head
);

  localparam int AW = CHANNELS;

  ephc_pkg::queue_entry_t slots [ephc_pkg::QUEUE_DEPTH];
  ephc_pkg::queue_entry_t entry;

  logic [ephc_pkg::QPTR_W-1:0] wr_ptr;
  logic [ephc_pkg::QPTR_W-1:0] rd_ptr;
  logic [ephc_pkg::QPTR_W:0]   fill;
  logic [ephc_pkg::EVENT_W-1:0] index_ext;
  logic full;
  logic keep;
  logic push;
  logic event_in_range;
  logic index_in_range;

  assign full = (fill == (ephc_pkg::QPTR_W + 1)'(ephc_pkg::QUEUE_DEPTH));

  assign index_ext      = ephc_pkg::EVENT_W'(item.bin_index);
  assign event_in_range = ((item.event_word >> CHANNELS) == '0);
  assign index_in_range = ((index_ext >> CHANNELS) == '0);

  // Out-of-range event words are accepted and dropped here; they never
  // reach the queue. Reads of missing bins are queued so results stay ordered.
  always_comb begin
    case (item.kind)
      ephc_pkg::KIND_COUNT: begin
        keep       = event_in_range;
        entry.op   = ephc_pkg::OP_COUNT;
        entry.addr = ephc_pkg::ADDR_MAX_W'(item.event_word[AW-1:0]);
      end
      default: begin
        keep       = 1'b1;
        entry.op   = index_in_range ? ephc_pkg::OP_READ : ephc_pkg::OP_READ_ZERO;
        entry.addr = ephc_pkg::ADDR_MAX_W'(index_ext[AW-1:0]);
      end
    endcase
  end

  assign item.ready = !clearing && !full;
  assign push       = item.valid && item.ready && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];

  `EPHC_NEVER(a_push_when_full, clk, rst, push && full, "queue written while full")
  `EPHC_NEVER(a_pop_when_empty, clk, rst, pop && (fill == '0), "queue read while empty")

endmodule

// File: rtl/ephc_back.sv
// Back end: bin memory, clearing pass, read-modify-write and the result register.
`include "event_pattern_histogram_core_macros.svh"

module ephc_back #(
  parameter int CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ephc_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  clearing,
  ephc_out_if.source            result
);

  localparam int AW       = CHANNELS;
  localparam int NUM_BINS = 1 << CHANNELS;

  logic [ephc_pkg::COUNT_W-1:0] mem [NUM_BINS];

  ephc_pkg::back_state_t state;
  ephc_pkg::back_state_t state_next;
  ephc_pkg::op_t         cur_op;

  logic [AW-1:0]                clr_addr;
  logic [AW-1:0]                cur_addr;
  logic [AW-1:0]                head_addr;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                mem_waddr;
  logic [ephc_pkg::COUNT_W-1:0] mem_wdata;
  logic [ephc_pkg::COUNT_W-1:0] rdata;
  logic [ephc_pkg::COUNT_W-1:0] out_count;
  logic [ephc_pkg::COUNT_W-1:0] out_load_val;
  logic                         mem_we;
  logic                         out_valid;
  logic                         out_load;
  logic                         out_free;

  assign head_addr = head.entry.addr[AW-1:0];
  assign out_free  = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ephc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // The read is issued when an entry is popped; its data is used in the
  // update cycle, where the read address is held so a stalled read keeps it.
  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    clearing     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur_addr;
    mem_wdata    = '0;
    rd_addr      = cur_addr;
    out_load     = 1'b0;
    out_load_val = '0;
    unique case (state)
      ephc_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = ephc_pkg::ST_IDLE;
        end
      end
      ephc_pkg::ST_IDLE: begin
        rd_addr = head_addr;
        if (head.valid) begin
          if (head.entry.op == ephc_pkg::OP_READ_ZERO) begin
            if (out_free) begin
              pop      = 1'b1;
              out_load = 1'b1;
            end
          end else begin
            pop        = 1'b1;
            state_next = ephc_pkg::ST_UPDATE;
          end
        end
      end
      ephc_pkg::ST_UPDATE: begin
        if (cur_op == ephc_pkg::OP_COUNT) begin
          mem_we     = 1'b1;
          mem_wdata  = (rdata == ephc_pkg::COUNT_MAX) ? rdata : rdata + 1'b1;
          state_next = ephc_pkg::ST_IDLE;
        end else if (out_free) begin
          mem_we       = 1'b1;
          out_load     = 1'b1;
          out_load_val = rdata;
          state_next   = ephc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ephc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ephc_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op   <= head.entry.op;
      cur_addr <= head_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count <= out_load_val;
    end
  end

  assign result.valid     = out_valid;
  assign result.bin_count = out_count;

  `EPHC_NEVER(a_result_during_clear, clk, rst, clearing && out_valid, "result during clearing pass")
  `EPHC_ASSERT(a_count_nonzero, clk, rst,
    (state == ephc_pkg::ST_UPDATE && cur_op == ephc_pkg::OP_COUNT) |-> (mem_wdata != '0),
    "counted bin written as zero")
  `EPHC_ASSERT(a_load_frees_output, clk, rst, out_load |-> out_free, "result register overwritten")

endmodule

// File: rtl/event_pattern_histogram_core.sv
// Path: a read of an existing bin goes from the queue through the bin memory read register
// and the update state to the result register; a read of a missing bin goes from the queue
// straight to the result register. Back end: counts and reads of existing bins each pass
// through the idle and update states, set by the read-then-write loop on the bin memory;
// reads of missing bins are answered from the idle state. Reset: a clearing pass writes zero
// to all 2^CHANNELS bins, one bin per cycle, and no item is taken until it ends.
module event_pattern_histogram_core #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ephc_in_if.sink     item,
  ephc_out_if.source  result
);

  ephc_pkg::queue_head_t head;
  logic                  pop;
  logic                  clearing;

  ephc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .clearing (clearing),
    .pop      (pop),
    .head     (head)
  );

  ephc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

endmodule

// File: dv/ephc_histogram_checker.sv
// Checker for the event pattern histogram core: tracks bin counts and compares read results.
`timescale 1ns / 100ps

module ephc_histogram_checker
  import ephc_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic clk,
  input  logic rst,
  ephc_in_if   item_mon,
  ephc_out_if  result_mon,
  output int   mismatches,
  output int   counts_owed
);

  localparam int NUM_BINS  = 1 << CHANNELS;
  localparam int PRINT_CAP = 200;

  // Bit type so the copy of the histogram starts at zero, as after the clearing pass.
  bit   [COUNT_W-1:0] bin_tally [NUM_BINS];
  logic [COUNT_W-1:0] owed_q [$];
  logic [COUNT_W-1:0] oldest_count;
  int                 error_total = 0;

  assign mismatches = error_total;

  task automatic report_mismatch(input string what);
    if (error_total < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    error_total++;
  endtask

  task automatic tally_item(input logic kind, input logic [EVENT_W-1:0] word,
                            input logic [INDEX_W-1:0] idx);
    if (kind == KIND_COUNT) begin
      // Words at or above 2^CHANNELS name no bin and are dropped.
      if ((word >> CHANNELS) == '0 && bin_tally[word] != COUNT_MAX) begin
        bin_tally[word] = bin_tally[word] + 1'b1;
      end
    end else if ((32'(idx) >> CHANNELS) == 0) begin
      owed_q = {owed_q, bin_tally[idx]};
      bin_tally[idx] = '0;
    end else begin
      owed_q = {owed_q, COUNT_W'(0)};
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_mon.valid && result_mon.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%08h with no read outstanding",
                                    result_mon.bin_count));
        end else begin
          oldest_count = owed_q.pop_front();
          if (result_mon.bin_count !== oldest_count) begin
            report_mismatch($sformatf("bin_count 0x%08h, expected 0x%08h",
                                      result_mon.bin_count, oldest_count));
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        tally_item(item_mon.kind, item_mon.event_word, item_mon.bin_index);
      end
    end
    counts_owed <= owed_q.size();
  end

  final begin
    if (owed_q.size() != 0) begin
      $display("MISMATCH: %0d read results never arrived", owed_q.size());
    end
  end

endmodule

// File: dv/tb_top.sv
// Top of the event pattern histogram core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import ephc_pkg::*;

  localparam int CHANNELS = 16;
  localparam int HOT_N    = 12;
  localparam int N_ITEMS  = 1830;
  localparam int TAIL_N   = 300;

  logic clk;
  logic rst;
  int   mismatches;
  int   counts_owed;
  int   idle_level = 0;

  logic [INDEX_W-1:0] hot_bins [HOT_N];

  ephc_in_if  item_ch ();
  ephc_out_if result_ch ();

  event_pattern_histogram_core #(.CHANNELS(CHANNELS)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ephc_histogram_checker #(.CHANNELS(CHANNELS)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_mon    (item_ch),
    .result_mon  (result_ch),
    .mismatches  (mismatches),
    .counts_owed (counts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit idle_roll();
    if (idle_level == 1) return $urandom_range(7) == 0;
    if (idle_level == 2) return $urandom_range(2) == 0;
    return 1'b0;
  endfunction

  // Result side: ready drops in bursts of random length.
  initial begin
    int stall;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else if (!rst && idle_roll()) begin
        result_ch.ready <= 1'b0;
        stall = $urandom_range(8, 0);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [EVENT_W-1:0] word,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    item_ch.valid      <= 1'b1;
    item_ch.kind       <= kind;
    item_ch.event_word <= word;
    item_ch.bin_index  <= idx;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    gap = idle_roll() ? $urandom_range(9, 1) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic count_word(input logic [EVENT_W-1:0] word);
    send_item(KIND_COUNT, word, INDEX_W'($urandom));
  endtask

  task automatic read_bin(input logic [INDEX_W-1:0] idx);
    send_item(KIND_READ, $urandom, idx);
  endtask

  // Holds the input side until every outstanding read has returned its count.
  task automatic wait_results_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (counts_owed != 0) @(posedge clk);
  endtask

  function automatic logic [EVENT_W-1:0] dropped_word();
    logic [EVENT_W-1:0] w;
    w = $urandom;
    if ($urandom_range(3) == 0) w = (EVENT_W'(1) << CHANNELS) + $urandom_range(3);
    if ((w >> CHANNELS) == '0) w[EVENT_W-1] = 1'b1;
    return w;
  endfunction

  task automatic pick_hot_bins();
    for (int i = 0; i < HOT_N; i++) begin
      // Some neighbors of the previous bin, to press on address hazards.
      if (i > 0 && $urandom_range(3) == 0) hot_bins[i] = hot_bins[i-1] + 1'b1;
      else hot_bins[i] = INDEX_W'($urandom);
    end
  endtask

  initial begin
    int done;
    int roll;
    int next_mark;
    item_ch.valid      <= 1'b0;
    item_ch.kind       <= KIND_COUNT;
    item_ch.event_word <= '0;
    item_ch.bin_index  <= '0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, back to back so that same-bin hazards meet in the pipeline.
    count_word(32'h0000_0000);
    count_word(32'h0000_0000);
    count_word(32'h0000_FFFF);
    count_word(32'h0001_0000);
    count_word(32'hFFFF_FFFF);
    count_word(32'h8000_0000);
    count_word(32'h0001_FFFF);
    send_item(KIND_COUNT, 32'h0000_5555, 16'hFFFF);
    send_item(KIND_READ, 32'hFFFF_FFFF, 16'h0000);
    read_bin(16'h0000);
    read_bin(16'hFFFF);
    count_word(32'h0000_1234);
    count_word(32'h0000_1234);
    count_word(32'h0000_1234);
    read_bin(16'h1234);
    count_word(32'h0000_1234);
    read_bin(16'h1234);
    read_bin(16'hAAAA);
    read_bin(16'h5555);
    count_word(32'h0000_AAAA);
    count_word(32'h0000_5555);
    read_bin(16'hAAAA);
    read_bin(16'h5555);
    wait_results_drained();

    // Random part: most traffic lands on a few hot bins that are read back and cleared.
    pick_hot_bins();
    done = 0;
    next_mark = 0;
    while (done < N_ITEMS) begin
      if (done >= next_mark) begin
        next_mark += 150;
        idle_level = (done >= N_ITEMS - TAIL_N) ? 0 : $urandom_range(2);
        if ($urandom_range(2) == 0) pick_hot_bins();
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
        // Read out the whole hot set, as at the end of a counting period.
        for (int i = 0; i < HOT_N; i++) read_bin(hot_bins[i]);
        done += HOT_N;
      end else if (roll < 56) begin
        count_word(EVENT_W'(hot_bins[$urandom_range(HOT_N - 1)]));
        done++;
      end else if (roll < 66) begin
        count_word($urandom_range((1 << CHANNELS) - 1));
        done++;
      end else if (roll < 73) begin
        count_word(dropped_word());
        done++;
      end else if (roll < 92) begin
        read_bin(hot_bins[$urandom_range(HOT_N - 1)]);
        done++;
      end else begin
        read_bin(INDEX_W'($urandom));
        done++;
      end
    end
    idle_level = 0;

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && counts_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ephc_pkg.sv
rtl/ephc_ifs.sv
rtl/ephc_front.sv
rtl/ephc_back.sv
rtl/event_pattern_histogram_core.sv
dv/ephc_histogram_checker.sv
dv/tb_top.sv
